// ----- rtl/core/hcbd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, character codes and helper functions shared by the chunked body
// decoder modules.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam logic [7:0]  C_CH_CR    = 8'h0D;
    localparam logic [7:0]  C_CH_LF    = 8'h0A;
    localparam logic [7:0]  C_CH_COLON = 8'h3A;
    localparam logic [7:0]  C_CH_DASH  = 8'h2D;
    localparam logic [7:0]  C_CH_UNDER = 8'h5F;
    localparam logic [7:0]  C_CH_0     = 8'h30;
    localparam logic [7:0]  C_CH_9     = 8'h39;
    localparam logic [7:0]  C_CH_UA    = 8'h41;
    localparam logic [7:0]  C_CH_UF    = 8'h46;
    localparam logic [7:0]  C_CH_UZ    = 8'h5A;
    localparam logic [7:0]  C_CH_LA    = 8'h61;
    localparam logic [7:0]  C_CH_LF_HEX = 8'h66;
    localparam logic [7:0]  C_CH_LZ    = 8'h7A;
    localparam logic [7:0]  C_HEX_TEN  = 8'd10;
    localparam logic [1:0]  C_SKIP_LEN = 2'd2;
    localparam logic [31:0] C_BODY_LIMIT_RST = 32'd1048576;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_LARGE = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_SIZE  = 6'b000001,
        PH_DATA  = 6'b000010,
        PH_SKIP  = 6'b000100,
        PH_KEY   = 6'b001000,
        PH_VALUE = 6'b010000,
        PH_DONE  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
    } t_item;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b0;
        if (c inside {[C_CH_0:C_CH_9]}) begin
            v  = c - C_CH_0;
            ok = 1'b1;
        end else if (c inside {[C_CH_UA:C_CH_UF]}) begin
            v  = c - C_CH_UA + C_HEX_TEN;
            ok = 1'b1;
        end else if (c inside {[C_CH_LA:C_CH_LF_HEX]}) begin
            v  = c - C_CH_LA + C_HEX_TEN;
            ok = 1'b1;
        end
        return {ok, v[3:0]};
    endfunction

    function automatic logic f_key_ok(input logic [7:0] c);
        return (c inside {C_CH_DASH, C_CH_UNDER, [C_CH_0:C_CH_9], [C_CH_UA:C_CH_UZ],
                          [C_CH_LA:C_CH_LZ]});
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/hcbd_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_in_if
// Raw byte channel into the chunked body decoder.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_message;

    modport source (output valid, output data_byte, output new_message, input ready);
    modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hcbd_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_out_if
// Result channel of the chunked body decoder, one transaction per input byte.
// ----------------------------------------------------------------------------
interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_valid;
    logic       done_res;
    logic [1:0] status;

    modport source (output valid, output body_byte, output body_valid, output done_res,
                    output status, input ready);
    modport sink   (input valid, input body_byte, input body_valid, input done_res,
                    input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hcbd_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_cfg_if
// Write channel for the body limit register.
// ----------------------------------------------------------------------------
interface hcbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hcbd_in_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_in_reg
// Input register stage; holds one accepted byte until the decoder takes it.
// ----------------------------------------------------------------------------
module hcbd_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    hcbd_in_if.sink              i_in,
    input  wire logic            i_take,
    output logic                 o_vld,
    output hcbd_pkg::t_item      o_item
);
    import hcbd_pkg::*;

    logic  r_vld;
    t_item r_item;
    logic  accept;

    assign i_in.ready = !r_vld || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte   <= i_in.data_byte;
            r_item.new_message <= i_in.new_message;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule
`default_nettype wire

// ----- rtl/core/hcbd_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_engine
// Decoder state, body limit register and result register. One byte per
// cycle goes from input to result register unless a result waits untaken.
// ----------------------------------------------------------------------------
module hcbd_engine #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  wire hcbd_pkg::t_item i_item,
    output logic                 o_take,
    hcbd_cfg_if.sink             i_cfg,
    hcbd_out_if.source           o_res
);
    import hcbd_pkg::*;

    logic [31:0]            r_body_limit;
    t_phase                 r_phase,  n_phase,  cur_phase;
    logic [LENGTH_BITS-1:0] r_chunk,  n_chunk,  cur_chunk;
    logic [31:0]            r_total,  n_total,  cur_total;
    logic [1:0]             r_skip,   n_skip,   cur_skip;
    logic                   r_cr,     n_cr,     cur_cr;
    logic                   r_keynz,  n_keynz,  cur_keynz;
    logic                   r_digits, n_digits, cur_digits;
    t_status                r_err,    n_err,    cur_err;
    logic                   n_valid;
    logic [7:0]             c;
    logic [4:0]             hexv;
    logic                   nm;

    logic                   r_res_vld;
    logic [7:0]             r_body_byte;
    logic                   r_body_valid;
    logic                   r_done;
    t_status                r_status;

    assign o_take      = i_vld && (!r_res_vld || o_res.ready);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        c    = i_item.data_byte;
        nm   = i_item.new_message;
        hexv = f_hex(c);

        cur_phase  = nm ? PH_SIZE : r_phase;
        cur_chunk  = nm ? '0      : r_chunk;
        cur_total  = nm ? '0      : r_total;
        cur_skip   = nm ? '0      : r_skip;
        cur_cr     = nm ? 1'b0    : r_cr;
        cur_keynz  = nm ? 1'b0    : r_keynz;
        cur_digits = nm ? 1'b0    : r_digits;
        cur_err    = nm ? ST_OK   : r_err;

        n_phase  = cur_phase;
        n_chunk  = cur_chunk;
        n_total  = cur_total;
        n_skip   = cur_skip;
        n_cr     = cur_cr;
        n_keynz  = cur_keynz;
        n_digits = cur_digits;
        n_err    = cur_err;
        n_valid  = 1'b0;

        case (cur_phase)
            PH_SIZE: begin
                if (cur_cr) begin
                    n_cr = 1'b0;
                    if (c != C_CH_LF || !cur_digits) begin
                        n_phase = PH_DONE;
                        n_err   = ST_BAD;
                    end else begin
                        n_digits = 1'b0;
                        if (cur_chunk == '0) begin
                            n_phase = PH_KEY;
                            n_keynz = 1'b0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end else if (c == C_CH_CR) begin
                    n_cr = 1'b1;
                end else if (!hexv[4]) begin
                    n_phase = PH_DONE;
                    n_err   = ST_BAD;
                end else if (cur_chunk[LENGTH_BITS-1:LENGTH_BITS-4] != 4'd0) begin
                    n_phase = PH_DONE;
                    n_err   = ST_LARGE;
                end else begin
                    n_chunk  = {cur_chunk[LENGTH_BITS-5:0], hexv[3:0]};
                    n_digits = 1'b1;
                end
            end
            PH_DATA: begin
                if (cur_total >= r_body_limit) begin
                    n_phase = PH_DONE;
                    n_err   = ST_LARGE;
                end else begin
                    n_total = cur_total + 32'd1;
                    n_valid = 1'b1;
                    n_chunk = cur_chunk - LENGTH_BITS'(1);
                    if (cur_chunk == LENGTH_BITS'(1)) begin
                        n_phase = PH_SKIP;
                        n_skip  = C_SKIP_LEN;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = cur_skip - 2'd1;
                if (n_skip == 2'd0) begin
                    n_phase  = PH_SIZE;
                    n_cr     = 1'b0;
                    n_digits = 1'b0;
                end
            end
            PH_KEY, PH_VALUE: begin
                if (cur_cr && c == C_CH_LF) begin
                    n_cr = 1'b0;
                    if (cur_phase == PH_KEY) begin
                        if (cur_keynz) begin
                            n_phase = PH_DONE;
                            n_err   = ST_BAD;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_phase = PH_KEY;
                        n_keynz = 1'b0;
                    end
                end else if (cur_cr && cur_phase == PH_KEY) begin
                    n_cr    = 1'b0;
                    n_phase = PH_DONE;
                    n_err   = ST_BAD;
                end else begin
                    n_cr = 1'b0;
                    if (c == C_CH_CR) begin
                        n_cr = 1'b1;
                    end else if (cur_phase == PH_KEY) begin
                        if (c == C_CH_COLON) begin
                            if (cur_keynz) begin
                                n_phase = PH_VALUE;
                            end else begin
                                n_phase = PH_DONE;
                                n_err   = ST_BAD;
                            end
                        end else if (!f_key_ok(c)) begin
                            n_phase = PH_DONE;
                            n_err   = ST_BAD;
                        end else begin
                            n_keynz = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_limit <= C_BODY_LIMIT_RST;
        end else if (i_cfg.valid) begin
            r_body_limit <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIZE;
            r_chunk  <= '0;
            r_total  <= '0;
            r_skip   <= '0;
            r_cr     <= 1'b0;
            r_keynz  <= 1'b0;
            r_digits <= 1'b0;
            r_err    <= ST_OK;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_chunk  <= n_chunk;
            r_total  <= n_total;
            r_skip   <= n_skip;
            r_cr     <= n_cr;
            r_keynz  <= n_keynz;
            r_digits <= n_digits;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (o_take) begin
            r_res_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_body_byte  <= n_valid ? c : 8'd0;
            r_body_valid <= n_valid;
            r_done       <= (n_phase == PH_DONE);
            r_status     <= n_err;
        end
    end

    assign o_res.valid      = r_res_vld;
    assign o_res.body_byte  = r_body_byte;
    assign o_res.body_valid = r_body_valid;
    assign o_res.done_res   = r_done;
    assign o_res.status     = r_status;
endmodule
`default_nettype wire

// ----- rtl/core/http_chunked_body_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Decodes an HTTP/1.1 chunked body one byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle while the result side is ready and
// returns exactly one result transaction per byte. A byte passes from an
// input register through the decoder state update into a result register,
// so a new byte is taken while the previous result still waits to be taken.
// The body limit may be written at any time the block is idle; no clearing
// pass follows reset.
module http_chunked_body_decoder_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_cfg_if.sink    i_cfg,
    hcbd_out_if.source  o_res
);
    import hcbd_pkg::*;

    logic  stage_vld;
    t_item stage_item;
    logic  take;

    hcbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_vld   (stage_vld),
        .o_item  (stage_item)
    );

    hcbd_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (stage_vld),
        .i_item  (stage_item),
        .o_take  (take),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

    a_payload_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.body_valid) |-> (!o_res.done_res && o_res.status == ST_OK))
        else $error("Payload byte reported on a finished body.");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.body_valid) |-> (o_res.body_byte == 8'd0))
        else $error("Body byte is not zero outside payload.");

    a_error_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.done_res) |-> (o_res.status == ST_OK))
        else $error("Error status without done.");

    a_result_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_res.valid)
        else $error("Decoded byte produced no result transaction.");
endmodule
`default_nettype wire

// ----- sim/hcbd_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcbd_tb_pkg
// Scoreboard for the chunked body decoder. It follows the decoder state for
// every accepted byte, queues the result that byte must produce, and checks
// each result transaction against the oldest queued result.
// ----------------------------------------------------------------------------
package hcbd_tb_pkg;
    import hcbd_pkg::*;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       done_res;
        logic [1:0] status;
    } t_decoded;

    class chunk_decoder_scoreboard #(int SIZE_BITS = 32);
        t_phase               phase;
        logic [SIZE_BITS-1:0] chunk_left;
        logic [31:0]          body_total;
        logic [31:0]          body_limit;
        logic [1:0]           skip_left;
        logic                 cr_seen;
        logic                 key_seen;
        logic                 size_seen;
        t_status              error_kind;
        t_decoded             expected_results[$];
        int                   fail_count;
        int                   report_count;

        function new();
            body_limit   = C_BODY_LIMIT_RST;
            fail_count   = 0;
            report_count = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_SIZE;
            chunk_left = '0;
            body_total = '0;
            skip_left  = '0;
            cr_seen    = 1'b0;
            key_seen   = 1'b0;
            size_seen  = 1'b0;
            error_kind = ST_OK;
        endfunction

        function void set_body_limit(input logic [31:0] value);
            body_limit = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void abort_body(input t_status kind);
            error_kind = kind;
            phase      = PH_DONE;
        endfunction

        function int hex_digit(input logic [7:0] c);
            if (c >= C_CH_0 && c <= C_CH_9) return int'(c - C_CH_0);
            if (c >= C_CH_UA && c <= C_CH_UF) return int'(c - C_CH_UA) + 10;
            if (c >= C_CH_LA && c <= C_CH_LF_HEX) return int'(c - C_CH_LA) + 10;
            return -1;
        endfunction

        function bit is_key_char(input logic [7:0] c);
            return c == C_CH_DASH || c == C_CH_UNDER ||
                   (c >= C_CH_0 && c <= C_CH_9) ||
                   (c >= C_CH_UA && c <= C_CH_UZ) ||
                   (c >= C_CH_LA && c <= C_CH_LZ);
        endfunction

        function void size_char(input logic [7:0] c);
            int nibble;
            nibble = hex_digit(c);
            if (cr_seen) begin
                cr_seen = 1'b0;
                if (c != C_CH_LF || !size_seen) begin
                    abort_body(ST_BAD);
                end else begin
                    size_seen = 1'b0;
                    if (chunk_left == 0) begin
                        phase    = PH_KEY;
                        key_seen = 1'b0;
                    end else begin
                        phase = PH_DATA;
                    end
                end
            end else if (c == C_CH_CR) begin
                cr_seen = 1'b1;
            end else if (nibble < 0) begin
                abort_body(ST_BAD);
            end else if ((chunk_left >> (SIZE_BITS - 4)) != 0) begin
                abort_body(ST_LARGE);
            end else begin
                chunk_left = {chunk_left[SIZE_BITS-5:0], nibble[3:0]};
                size_seen  = 1'b1;
            end
        endfunction

        function void trailer_char(input logic [7:0] c);
            if (cr_seen) begin
                cr_seen = 1'b0;
                if (c == C_CH_LF) begin
                    if (phase == PH_KEY) begin
                        if (key_seen) abort_body(ST_BAD);
                        else phase = PH_DONE;
                    end else begin
                        phase    = PH_KEY;
                        key_seen = 1'b0;
                    end
                    return;
                end
                if (phase == PH_KEY) begin
                    abort_body(ST_BAD);
                    return;
                end
            end
            if (c == C_CH_CR) begin
                cr_seen = 1'b1;
                return;
            end
            if (phase == PH_VALUE) return;
            if (c == C_CH_COLON) begin
                if (!key_seen) abort_body(ST_BAD);
                else phase = PH_VALUE;
                return;
            end
            if (!is_key_char(c)) begin
                abort_body(ST_BAD);
                return;
            end
            key_seen = 1'b1;
        endfunction

        function void note_byte(input logic [7:0] c, input logic new_message);
            t_decoded result;
            result = '0;
            if (new_message) restart();
            case (phase)
                PH_SIZE: size_char(c);
                PH_DATA: begin
                    if (body_total >= body_limit) begin
                        abort_body(ST_LARGE);
                    end else begin
                        body_total++;
                        result.body_valid = 1'b1;
                        result.body_byte  = c;
                        chunk_left--;
                        if (chunk_left == 0) begin
                            phase     = PH_SKIP;
                            skip_left = C_SKIP_LEN;
                        end
                    end
                end
                PH_SKIP: begin
                    skip_left--;
                    if (skip_left == 0) begin
                        phase     = PH_SIZE;
                        cr_seen   = 1'b0;
                        size_seen = 1'b0;
                    end
                end
                PH_KEY, PH_VALUE: trailer_char(c);
                default: phase = PH_DONE;
            endcase
            result.done_res = (phase == PH_DONE);
            result.status   = error_kind;
            expected_results.push_back(result);
        endfunction

        function void check_result(input logic [7:0] body_byte, input logic body_valid,
                                   input logic done_res, input logic [1:0] status);
            t_decoded want;
            t_decoded got;
            got = {body_byte, body_valid, done_res, status};
            if (expected_results.size() == 0) begin
                fail_count++;
                if (report_count < 10) begin
                    report_count++;
                    $display("Unexpected result: byte=%02h valid=%0b done=%0b status=%0d",
                             body_byte, body_valid, done_res, status);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                fail_count++;
                if (report_count < 10) begin
                    report_count++;
                    $display({"Result mismatch: expected byte=%02h valid=%0b done=%0b ",
                              "status=%0d, got byte=%02h valid=%0b done=%0b status=%0d"},
                             want.body_byte, want.body_valid, want.done_res, want.status,
                             body_byte, body_valid, done_res, status);
                end
            end
        endfunction
    endclass

endpackage

// ----- sim/http_chunked_body_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit_tb
// Feeds chunked bodies, broken bodies and noise into the decoder under
// random idling on both channels, moves the body limit through several
// values between phases, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit_tb;
    import hcbd_pkg::*;
    import hcbd_tb_pkg::*;

    localparam int SIZE_BITS    = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int MAX_GAP      = 13;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    int         cycle_count = 0;
    bit         in_quiet    = 1'b0;
    bit         out_quiet   = 1'b0;
    logic [7:0] msg_q[$];

    hcbd_tb_pkg::chunk_decoder_scoreboard #(.SIZE_BITS(SIZE_BITS)) sb;

    hcbd_in_if  in_if();
    hcbd_cfg_if cfg_if();
    hcbd_out_if res_if();

    http_chunked_body_decoder_unit #(
        .LENGTH_BITS(SIZE_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.body_byte, res_if.body_valid, res_if.done_res,
                            res_if.status);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : result_sink
        int gap;
        res_if.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic new_message);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= c;
        in_if.new_message <= new_message;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(c, new_message);
    endtask

    task automatic send_message(input bit start_new);
        foreach (msg_q[i]) send_byte(msg_q[i], (i == 0) && start_new);
        msg_q.delete();
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_body_limit(input logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.set_body_limit(value);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endfunction

    function automatic void add_crlf();
        msg_q.push_back(C_CH_CR);
        msg_q.push_back(C_CH_LF);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        if (nibble < 10) return C_CH_0 + nibble;
        return 8'(($urandom_range(0, 1) ? C_CH_UA : C_CH_LA) + nibble - 10);
    endfunction

    function automatic logic [7:0] key_char_pick();
        case ($urandom_range(0, 4))
            0:       return 8'(C_CH_UA + $urandom_range(0, 25));
            1:       return 8'(C_CH_LA + $urandom_range(0, 25));
            2:       return 8'(C_CH_0 + $urandom_range(0, 9));
            3:       return C_CH_DASH;
            default: return C_CH_UNDER;
        endcase
    endfunction

    function automatic void add_size_line(input logic [31:0] value, input int pad);
        int top;
        top = 0;
        for (int i = 0; i < 8; i++) if (value[i*4 +: 4] != 0) top = i;
        repeat (pad) msg_q.push_back(C_CH_0);
        for (int i = top; i >= 0; i--) msg_q.push_back(hex_char(value[i*4 +: 4]));
        add_crlf();
    endfunction

    function automatic void add_payload(input int count);
        repeat (count) msg_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_key(input int count);
        repeat (count) msg_q.push_back(key_char_pick());
    endfunction

    function automatic void add_chunks(input int count);
        int chunk_len;
        repeat (count) begin
            chunk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
            add_size_line(chunk_len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            add_payload(chunk_len);
            if ($urandom_range(0, 3) == 0) add_payload(2);
            else add_crlf();
        end
    endfunction

    function automatic void add_trailer_line();
        logic [7:0] c;
        add_key($urandom_range(1, 5));
        msg_q.push_back(C_CH_COLON);
        repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(0, 255));
            msg_q.push_back((c == C_CH_CR) ? C_CH_COLON : c);
        end
        add_crlf();
    endfunction

    function automatic void add_good_body();
        add_chunks($urandom_range(0, 3));
        add_size_line(0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        repeat ($urandom_range(0, 2)) add_trailer_line();
        add_crlf();
    endfunction

    function automatic void add_broken_body(input int kind);
        case (kind)
            0: add_crlf();
            1: begin
                msg_q.push_back(hex_char(4'($urandom_range(0, 15))));
                msg_q.push_back(C_CH_CR);
                msg_q.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            2: begin
                msg_q.push_back(hex_char(4'($urandom_range(1, 15))));
                add_text(";name=1");
                add_crlf();
                add_payload(4);
            end
            3: begin
                msg_q.push_back(hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(8, 9)) begin
                    msg_q.push_back(hex_char(4'($urandom_range(0, 15))));
                end
                add_crlf();
            end
            4: begin
                add_chunks($urandom_range(0, 1));
                add_size_line(0, 0);
                add_key($urandom_range(0, 3));
                msg_q.push_back(8'($urandom_range(128, 255)));
                add_key(2);
            end
            5: begin
                add_chunks($urandom_range(0, 1));
                add_size_line(0, 0);
                msg_q.push_back(C_CH_COLON);
                add_key(2);
                add_crlf();
                add_crlf();
            end
            6: begin
                add_chunks($urandom_range(0, 1));
                add_size_line(0, 0);
                add_key($urandom_range(1, 4));
                add_crlf();
            end
            7: begin
                add_chunks($urandom_range(0, 1));
                add_size_line(0, 0);
                add_key($urandom_range(1, 3));
                msg_q.push_back(C_CH_CR);
                add_key(2);
            end
            default: begin
                add_size_line(32'hFFFF_FFFF, 0);
                add_payload($urandom_range(1, 20));
            end
        endcase
    endfunction

    function automatic void build_random_message();
        int pick;
        int keep;
        pick = $urandom_range(0, 19);
        if (pick <= 11) begin
            add_good_body();
            if ($urandom_range(0, 3) == 0) add_payload($urandom_range(1, 2));
        end else if (pick <= 13) begin
            add_good_body();
            msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick == 14) begin
            add_good_body();
            keep = $urandom_range(1, msg_q.size());
            while (msg_q.size() > keep) void'(msg_q.pop_back());
        end else if (pick <= 17) begin
            add_broken_body($urandom_range(0, 8));
        end else begin
            add_payload($urandom_range(1, 8));
        end
    endfunction

    task automatic run_random(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 11) == 0) in_quiet = !in_quiet;
            if ($urandom_range(0, 11) == 0) out_quiet = !out_quiet;
            build_random_message();
            sent += msg_q.size();
            send_message($urandom_range(0, 15) != 0);
        end
    endtask

    initial begin : stimulus
        logic [31:0] limit_plan[$];
        int          share;
        sb                = new();
        in_if.valid       = 1'b0;
        in_if.data_byte   = '0;
        in_if.new_message = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_text("2");
        add_crlf();
        msg_q.push_back(8'h00);
        msg_q.push_back(8'hFF);
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        msg_q.push_back(8'hFF);
        send_message(1'b1);
        add_text("g");
        send_message(1'b1);
        add_text("0");
        add_crlf();
        msg_q.push_back(C_CH_COLON);
        send_message(1'b1);
        add_text("0");
        add_crlf();
        add_text("k");
        add_crlf();
        send_message(1'b1);

        limit_plan.push_back(32'd0);
        limit_plan.push_back(32'd1);
        limit_plan.push_back(32'hFFFF_FFFF);
        limit_plan.push_back($urandom_range(2, 40));
        limit_plan.push_back($urandom);
        limit_plan.push_back($urandom_range(2, 40));
        limit_plan.push_back(C_BODY_LIMIT_RST);
        share = RANDOM_ITEMS / (limit_plan.size() + 1);

        run_random(share);
        foreach (limit_plan[i]) begin
            wait_idle();
            write_body_limit(limit_plan[i]);
            run_random(share);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_in_if.sv
rtl/core/hcbd_out_if.sv
rtl/core/hcbd_cfg_if.sv
rtl/core/hcbd_in_reg.sv
rtl/core/hcbd_engine.sv
rtl/core/http_chunked_body_decoder_unit.sv
sim/hcbd_tb_pkg.sv
sim/http_chunked_body_decoder_unit_tb.sv
